/* rtl/slaf_pkg.sv */
// Package: shared types and constants of the SUMP-style analyzer front end.
`timescale 1ns / 1ps

package slaf_pkg;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_HOST   = 2'd1,
		KIND_BUTTON = 2'd2
	} slaf_kind_t;

	localparam logic [7:0] CMD_RESET     = 8'h00;
	localparam logic [7:0] CMD_ARM       = 8'h01;
	localparam logic [7:0] CMD_QUERY_ID  = 8'h02;
	localparam logic [7:0] CMD_FINISH    = 8'h05;
	localparam logic [7:0] CMD_SET_MASK  = 8'hC0;
	localparam logic [7:0] CMD_SET_VALUE = 8'hC1;

	localparam logic [2:0] ARG_COUNT = 3'd4;
	localparam logic [7:0] MASK_RESET = 8'hFF;
	localparam logic [7:0] VALUE_RESET = 8'h00;

	// reply characters "1ALS", first character at index 0
	localparam logic [3:0][7:0] ID_REPLY = {8'h53, 8'h4C, 8'h41, 8'h31};
	localparam logic [1:0] ID_LAST_STEP = 2'd3;

	typedef struct packed {
		logic       id_reply;
		logic       send_valid;
		logic [7:0] send_byte;
		logic       changed;
		logic       armed_now;
	} slaf_job_t;

endpackage

/* rtl/slaf_front.sv */
// Front part: classifies input items, runs sampling and the command parser, issues jobs.
`timescale 1ns / 1ps

module slaf_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [1:0]          kind,
	input  logic [7:0]          port_a_pins,
	input  logic [3:0]          port_b_pins,
	input  logic [3:0]          port_c_pins,
	input  logic [7:0]          host_byte,
	output slaf_pkg::slaf_job_t job
);
	import slaf_pkg::*;

	logic       armed_q;
	logic [7:0] mask_q;
	logic [7:0] value_q;
	logic [7:0] prev_q;
	logic [7:0] opcode_q;
	logic [2:0] args_left_q;
	logic [7:0] first_arg_q;

	logic       armed_d;
	logic [7:0] mask_d;
	logic [7:0] value_d;
	logic [7:0] prev_d;
	logic [7:0] opcode_d;
	logic [2:0] args_left_d;
	logic [7:0] first_arg_d;

	logic [7:0] pins;
	logic [7:0] sample;

	assign pins = {port_a_pins[7:6], port_a_pins[4], port_b_pins[3:2], port_c_pins[3],
		port_c_pins[1:0]};
	assign sample = (pins ^ value_q) & mask_q;

	always_comb begin
		armed_d     = armed_q;
		mask_d      = mask_q;
		value_d     = value_q;
		prev_d      = prev_q;
		opcode_d    = opcode_q;
		args_left_d = args_left_q;
		first_arg_d = first_arg_q;
		job         = '0;
		unique case (kind)
			KIND_SAMPLE: begin
				prev_d         = sample;
				job.send_valid = armed_q;
				job.send_byte  = armed_q ? sample : 8'h00;
				job.changed    = (sample != prev_q);
			end
			KIND_HOST: begin
				priority if (args_left_q != 3'd0) begin
					if (args_left_q == ARG_COUNT)
						first_arg_d = host_byte;
					args_left_d = args_left_q - 3'd1;
					if (args_left_q == 3'd1) begin
						if (opcode_q == CMD_SET_MASK)
							mask_d = first_arg_q;
						else if (opcode_q == CMD_SET_VALUE)
							value_d = first_arg_q;
					end
				end else if (host_byte[7]) begin
					opcode_d    = host_byte;
					args_left_d = ARG_COUNT;
				end else if (host_byte == CMD_RESET || host_byte == CMD_FINISH) begin
					armed_d = 1'b0;
				end else if (host_byte == CMD_ARM) begin
					armed_d = 1'b1;
				end else if (host_byte == CMD_QUERY_ID) begin
					job.id_reply = 1'b1;
				end else begin
				end
			end
			KIND_BUTTON: armed_d = ~armed_q;
			default: begin
			end
		endcase
		job.armed_now = armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			mask_q      <= MASK_RESET;
			value_q     <= VALUE_RESET;
			prev_q      <= 8'h00;
			opcode_q    <= 8'h00;
			args_left_q <= 3'd0;
			first_arg_q <= 8'h00;
		end else if (accept) begin
			armed_q     <= armed_d;
			mask_q      <= mask_d;
			value_q     <= value_d;
			prev_q      <= prev_d;
			opcode_q    <= opcode_d;
			args_left_q <= args_left_d;
			first_arg_q <= first_arg_d;
		end
	end

endmodule

/* rtl/slaf_queue.sv */
// Job queue between front and back parts.
`timescale 1ns / 1ps

module slaf_queue #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  slaf_pkg::slaf_job_t push_job,
	input  logic                pop,
	output slaf_pkg::slaf_job_t head_job,
	output logic                full,
	output logic                empty
);
	import slaf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	slaf_job_t          mem [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/slaf_back.sv */
// Back part: expands jobs into result transfers and holds the output register.
`timescale 1ns / 1ps

module slaf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  slaf_pkg::slaf_job_t head_job,
	input  logic                empty,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                out_send_valid,
	output logic [7:0]          out_send_byte,
	output logic                out_last,
	output logic                out_changed,
	output logic                out_armed_now
);
	import slaf_pkg::*;

	logic       valid_q;
	logic       send_valid_q;
	logic [7:0] send_byte_q;
	logic       last_q;
	logic       changed_q;
	logic       armed_now_q;
	logic [1:0] step_q;
	logic       load;
	logic       id_done;

	assign load    = !valid_q || out_ready;
	assign id_done = (step_q == ID_LAST_STEP);
	assign pop     = load && !empty && (!head_job.id_reply || id_done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= 2'd0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty && head_job.id_reply)
				step_q <= id_done ? 2'd0 : step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			armed_now_q <= head_job.armed_now;
			if (head_job.id_reply) begin
				send_valid_q <= 1'b1;
				send_byte_q  <= ID_REPLY[step_q];
				last_q       <= id_done;
				changed_q    <= 1'b0;
			end else begin
				send_valid_q <= head_job.send_valid;
				send_byte_q  <= head_job.send_byte;
				last_q       <= 1'b1;
				changed_q    <= head_job.changed;
			end
		end
	end

	assign out_valid      = valid_q;
	assign out_send_valid = send_valid_q;
	assign out_send_byte  = send_byte_q;
	assign out_last       = last_q;
	assign out_changed    = changed_q;
	assign out_armed_now  = armed_now_q;

endmodule

/* rtl/sump_logic_analyzer_front_top.sv */
// Top level of the SUMP-style logic analyzer front end.
`timescale 1ns / 1ps

// Input stream (s_*): one item per transfer. tuser carries the item kind (pin sample,
// host command byte, arm button); tdata carries the port pins and the host byte.
// Output stream (m_*): one result per transfer; tlast marks the final result of an item,
// tuser[0] says whether tdata[7:0] goes to the host.
// An accepted item is written into the job queue and then loaded into the output register,
// where its result appears on m_tvalid. Input: one item per cycle while the queue is not
// full; a query-ID command produces four results and occupies four output transfers.
// The front part (sampling, parser, arming) and back part (result expansion, output
// register) are parted by a QUEUE_DEPTH-entry job queue; s_tready drops only when the
// queue is full, so a stalled receiver backs up into the queue before the input stalls.
// Reset: disarmed, trigger mask 0xFF, trigger value 0x00, no long command open, queue
// and output register empty.

module sump_logic_analyzer_front_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // port_a_pins[7:0], port_b_pins[11:8],
	                              // port_c_pins[15:12], host_byte[23:16]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // send_byte[7:0], changed[8], armed_now[9], zero fill
	output logic        m_tuser,  // send_valid[0]
	output logic        m_tlast
);
	import slaf_pkg::*;

	slaf_job_t  front_job;
	slaf_job_t  head_job;
	logic       accept;
	logic       q_full;
	logic       q_empty;
	logic       pop;
	logic [7:0] send_byte;
	logic       changed;
	logic       armed_now;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	slaf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.kind        (s_tuser),
		.port_a_pins (s_tdata[7:0]),
		.port_b_pins (s_tdata[11:8]),
		.port_c_pins (s_tdata[15:12]),
		.host_byte   (s_tdata[23:16]),
		.job         (front_job)
	);

	slaf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_job (front_job),
		.pop      (pop),
		.head_job (head_job),
		.full     (q_full),
		.empty    (q_empty)
	);

	slaf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_job       (head_job),
		.empty          (q_empty),
		.pop            (pop),
		.out_ready      (m_tready),
		.out_valid      (m_tvalid),
		.out_send_valid (m_tuser),
		.out_send_byte  (send_byte),
		.out_last       (m_tlast),
		.out_changed    (changed),
		.out_armed_now  (armed_now)
	);

	assign m_tdata = {6'd0, armed_now, changed, send_byte};

	a_mid_is_reply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tuser && !m_tdata[8])
		else $error("non-final result that is not an ID reply character");

	a_unsent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'h00)
		else $error("unsent result carries a nonzero byte");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_full && q_empty))
		else $error("queue full and empty at once");

	a_pop_feeds_out: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("queue pop without a final result in the output register");

endmodule
